/* rtl/core/assert_macros.svh */
// Assertion macros used by the sequencer module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define SKDT_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define SKDT_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/skdt_pkg.sv */
// Types and codes shared by the sorted key table modules
package skdt_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT       = 2'd0,
    KIND_LOOKUP_VALUE = 2'd1,
    KIND_LOOKUP_DEPTH = 2'd2,
    KIND_CLEAR        = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_UPDATED  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_HIT_CHK,
    S_ACT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } seq_state_t;

  // One stored entry
  typedef struct packed {
    logic [63:0]        key;
    logic signed [31:0] value;
    logic [7:0]         depth;
  } entry_t;

  // One request item
  typedef struct packed {
    kind_t  kind;
    entry_t entry;
  } req_t;

  // One result item
  typedef struct packed {
    status_t            status;
    logic signed [31:0] found_value;
    logic [7:0]         found_depth;
    logic [6:0]         entry_count;
  } rsp_t;

  // Sequencer status seen by the stream wrapper
  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

/* rtl/core/skdt_mem.sv */
// Entry memory: one write port, one registered read port
module skdt_mem #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  skdt_pkg::entry_t              wdata,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output skdt_pkg::entry_t              rdata
);

  skdt_pkg::entry_t mem [DEPTH];

  // Write entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/skdt_seq.sv */
// Sequencer: binary search, hit check and shift insert over the entry memory
`include "assert_macros.svh"

module skdt_seq #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  skdt_pkg::req_t                req,
  input  logic                          out_stall,
  output skdt_pkg::seq_stat_t           stat,
  output skdt_pkg::rsp_t                rsp,
  output logic                          mem_we,
  output logic [$clog2(CAPACITY)-1:0]   mem_waddr,
  output skdt_pkg::entry_t              mem_wdata,
  output logic [$clog2(CAPACITY)-1:0]   mem_raddr,
  input  skdt_pkg::entry_t              mem_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  skdt_pkg::seq_state_t state, state_next;
  skdt_pkg::req_t       req_r;
  skdt_pkg::rsp_t       rsp_r, rsp_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        lo, lo_next;
  logic [CW-1:0]        hi, hi_next;
  logic [CW-1:0]        idx, idx_next;
  logic                 hit, hit_next;
  logic [CW-1:0]        mid;
  logic [CW-1:0]        idx_dec;

  assign mid     = lo + ((hi - lo) >> 1);
  assign idx_dec = idx - ONE;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skdt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold entry count, clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Working registers of the search and shift
  always_ff @(posedge clk) begin
    if (start && state == skdt_pkg::S_IDLE) begin
      req_r <= req;
    end
    lo    <= lo_next;
    hi    <= hi_next;
    idx   <= idx_next;
    hit   <= hit_next;
    rsp_r <= rsp_next;
  end

  // Next state, memory access and result
  always_comb begin
    state_next = state;
    count_next = count;
    lo_next    = lo;
    hi_next    = hi;
    idx_next   = idx;
    hit_next   = hit;
    rsp_next   = rsp_r;
    mem_we     = 1'b0;
    mem_waddr  = lo[AW-1:0];
    mem_wdata  = req_r.entry;
    mem_raddr  = lo[AW-1:0];

    unique case (state)
      skdt_pkg::S_IDLE: begin
        if (start) begin
          lo_next  = '0;
          hi_next  = count;
          hit_next = 1'b0;
          state_next = (req.kind == skdt_pkg::KIND_CLEAR) ? skdt_pkg::S_ACT
                                                          : skdt_pkg::S_SRCH;
        end
      end

      // Narrow the range or resolve the insertion point
      skdt_pkg::S_SRCH: begin
        if (lo < hi) begin
          mem_raddr  = mid[AW-1:0];
          state_next = skdt_pkg::S_CMP;
        end else if (lo < count) begin
          state_next = skdt_pkg::S_HIT_CHK;
        end else begin
          hit_next   = 1'b0;
          state_next = skdt_pkg::S_ACT;
        end
      end

      // Compare the probed key with the request key
      skdt_pkg::S_CMP: begin
        if (mem_rdata.key < req_r.entry.key) begin
          lo_next = mid + ONE;
        end else begin
          hi_next = mid;
        end
        state_next = skdt_pkg::S_SRCH;
      end

      skdt_pkg::S_HIT_CHK: begin
        hit_next   = (mem_rdata.key == req_r.entry.key);
        state_next = skdt_pkg::S_ACT;
      end

      // Act on the search result
      skdt_pkg::S_ACT: begin
        rsp_next.status      = skdt_pkg::ST_MISS;
        rsp_next.found_value = '0;
        rsp_next.found_depth = '0;
        rsp_next.entry_count = '0;
        state_next           = skdt_pkg::S_DONE;
        unique case (req_r.kind)
          skdt_pkg::KIND_CLEAR: begin
            count_next      = '0;
            rsp_next.status = skdt_pkg::ST_HIT;
          end
          skdt_pkg::KIND_LOOKUP_VALUE: begin
            if (hit) begin
              rsp_next.status      = skdt_pkg::ST_HIT;
              rsp_next.found_value = mem_rdata.value;
            end
          end
          skdt_pkg::KIND_LOOKUP_DEPTH: begin
            if (hit) begin
              rsp_next.status      = skdt_pkg::ST_HIT;
              rsp_next.found_depth = mem_rdata.depth;
            end
          end
          skdt_pkg::KIND_INSERT: begin
            if (hit) begin
              mem_we          = 1'b1;
              mem_wdata       = mem_rdata;
              mem_wdata.depth = req_r.entry.depth;
              rsp_next.status = skdt_pkg::ST_UPDATED;
            end else if (count >= CAP) begin
              rsp_next.status = skdt_pkg::ST_FULL;
            end else begin
              idx_next   = count;
              state_next = skdt_pkg::S_SHIFT_RD;
            end
          end
          default: ;
        endcase
      end

      // Read the entry below the gap, or drop the new entry in
      skdt_pkg::S_SHIFT_RD: begin
        if (idx > lo) begin
          mem_raddr  = idx_dec[AW-1:0];
          state_next = skdt_pkg::S_SHIFT_WR;
        end else begin
          mem_we          = 1'b1;
          mem_waddr       = lo[AW-1:0];
          mem_wdata       = req_r.entry;
          count_next      = count + ONE;
          rsp_next.status = skdt_pkg::ST_INSERTED;
          state_next      = skdt_pkg::S_DONE;
        end
      end

      // Move that entry up one slot
      skdt_pkg::S_SHIFT_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[AW-1:0];
        mem_wdata  = mem_rdata;
        idx_next   = idx_dec;
        state_next = skdt_pkg::S_SHIFT_RD;
      end

      skdt_pkg::S_DONE: begin
        if (!out_stall) begin
          state_next = skdt_pkg::S_IDLE;
        end
      end

      default: state_next = skdt_pkg::S_IDLE;
    endcase
  end

  // Status and result towards the stream side
  always_comb begin
    stat.idle       = (state == skdt_pkg::S_IDLE);
    stat.done       = (state == skdt_pkg::S_DONE);
    rsp             = rsp_r;
    rsp.entry_count = 7'(count);
  end

  `SKDT_ASSERT_RST(a_count_cap, clk, rst, count <= CAP, "entry count above capacity")
  `SKDT_ASSERT_RST(a_we_state, clk, rst, mem_we |-> (state == skdt_pkg::S_ACT || state == skdt_pkg::S_SHIFT_RD || state == skdt_pkg::S_SHIFT_WR), "write outside update states")
  `SKDT_ASSERT_RST(a_range, clk, rst, (state == skdt_pkg::S_SRCH) |-> (lo <= hi && hi <= count), "search range broken")
  `SKDT_ASSERT_RST(a_shift_above, clk, rst, (state == skdt_pkg::S_SHIFT_WR) |-> (idx > lo && idx <= count), "shift outside moved span")
  `SKDT_ASSERT_RST(a_done_hold, clk, rst, (state == skdt_pkg::S_DONE && out_stall) |=> (state == skdt_pkg::S_DONE), "result dropped while stalled")

endmodule

/* rtl/core/sorted_key_depth_table.sv */
// A clear finishes without a search; a lookup or update runs the binary search first.
// A new-key insert then moves each entry above its slot up one slot and writes the new entry.
// s_tready stays low from acceptance until the result loads into the output register.
// One item at a time: the search compare and the one-read one-write memory set the pace.
// A new item is taken while the previous result still waits at the output register.
// Reset (rst, synchronous) empties the table and drops any held result; no clearing pass.
module sorted_key_depth_table #(
  parameter int CAPACITY = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // key[63:0], entry_value[95:64], entry_depth[103:96]
  input  logic [1:0]   s_tuser,   // kind[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,   // found_value[31:0], found_depth[39:32],
                                  // entry_count[46:40], zero[47]
  output logic [2:0]   m_tuser    // status[2:0]
);

  localparam int AW = $clog2(CAPACITY);

  skdt_pkg::req_t      req;
  skdt_pkg::rsp_t      rsp;
  skdt_pkg::seq_stat_t stat;
  skdt_pkg::entry_t    mem_wdata, mem_rdata;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic                mem_we;
  logic                start;
  logic                out_stall;
  logic                out_load;

  // Unpack the request item
  assign req.kind        = skdt_pkg::kind_t'(s_tuser);
  assign req.entry.key   = s_tdata[63:0];
  assign req.entry.value = s_tdata[95:64];
  assign req.entry.depth = s_tdata[103:96];

  assign s_tready  = stat.idle;
  assign start     = s_tvalid && s_tready;
  assign out_stall = m_tvalid && !m_tready;
  assign out_load  = stat.done && !out_stall;

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Load the result item
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= rsp.status;
      m_tdata <= {1'b0, rsp.entry_count, rsp.found_depth, rsp.found_value};
    end
  end

  skdt_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .out_stall (out_stall),
    .stat      (stat),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  skdt_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* verif/skdt_table_checker.sv */
// Checker for the sorted key table: tracks the table contents and compares each result item
module skdt_table_checker #(
  parameter int CAPACITY = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [103:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [47:0]  m_tdata,
  input  logic [2:0]   m_tuser,
  output int           fail_count,
  output int           results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 100;

  // Shadow of the table, kept in ascending key order
  logic [63:0]        tbl_key [CAPACITY];
  logic signed [31:0] tbl_val [CAPACITY];
  logic [7:0]         tbl_dep [CAPACITY];
  int unsigned        tbl_count = 0;

  skdt_pkg::rsp_t awaited_results [$];
  int   mismatches = 0;
  int   due_count  = 0;

  assign fail_count  = mismatches;
  assign results_due = due_count;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: %s mismatch: got 0x%0h, wanted 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // First slot whose key is not below k
  function automatic int unsigned key_slot(input logic [63:0] k);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (tbl_key[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Apply one request to the shadow table and work out its result item
  task automatic apply_to_table(input skdt_pkg::kind_t kind, input logic [63:0] k,
                                input logic signed [31:0] v, input logic [7:0] d,
                                output skdt_pkg::rsp_t r);
    int unsigned pos;
    int unsigned i;
    logic        hit;
    r = '0;
    r.status = skdt_pkg::ST_MISS;
    if (kind == skdt_pkg::KIND_CLEAR) begin
      tbl_count = 0;
      r.status = skdt_pkg::ST_HIT;
    end else begin
      pos = key_slot(k);
      hit = (pos < tbl_count) && (tbl_key[pos] == k);
      case (kind)
        skdt_pkg::KIND_INSERT: begin
          if (hit) begin
            tbl_dep[pos] = d;
            r.status = skdt_pkg::ST_UPDATED;
          end else if (tbl_count >= CAPACITY) begin
            r.status = skdt_pkg::ST_FULL;
          end else begin
            // shift larger entries up one slot
            for (i = tbl_count; i > pos; i--) begin
              tbl_key[i] = tbl_key[i-1];
              tbl_val[i] = tbl_val[i-1];
              tbl_dep[i] = tbl_dep[i-1];
            end
            tbl_key[pos] = k;
            tbl_val[pos] = v;
            tbl_dep[pos] = d;
            tbl_count++;
            r.status = skdt_pkg::ST_INSERTED;
          end
        end
        skdt_pkg::KIND_LOOKUP_VALUE: begin
          if (hit) begin
            r.status = skdt_pkg::ST_HIT;
            r.found_value = tbl_val[pos];
          end
        end
        default: begin
          if (hit) begin
            r.status = skdt_pkg::ST_HIT;
            r.found_depth = tbl_dep[pos];
          end
        end
      endcase
    end
    r.entry_count = tbl_count[6:0];
  endtask

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin : watch
    skdt_pkg::rsp_t want;
    if (rst) begin
      tbl_count = 0;
      awaited_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        apply_to_table(skdt_pkg::kind_t'(s_tuser), s_tdata[63:0], s_tdata[95:64],
                       s_tdata[103:96], want);
        awaited_results.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unrequested result", 64'({m_tuser, m_tdata}), '0);
        end else begin
          want = awaited_results.pop_front();
          if (m_tuser !== want.status)
            report_mismatch("status", 64'(m_tuser), 64'(want.status));
          if (m_tdata[31:0] !== want.found_value)
            report_mismatch("found_value", {32'd0, m_tdata[31:0]},
                            {32'd0, want.found_value});
          if (m_tdata[39:32] !== want.found_depth)
            report_mismatch("found_depth", 64'(m_tdata[39:32]), 64'(want.found_depth));
          if (m_tdata[46:40] !== want.entry_count)
            report_mismatch("entry_count", 64'(m_tdata[46:40]), 64'(want.entry_count));
          if (m_tdata[47] !== 1'b0)
            report_mismatch("pad bit", 64'(m_tdata[47]), 64'(1'b0));
        end
      end
    end
    due_count <= awaited_results.size();
  end

endmodule

/* verif/testbench.sv */
// Top of the sorted key table testbench: clock, reset, request stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY        = 64;
  localparam int POOL_SIZE       = 100;
  localparam int ITEM_TARGET     = 850;
  localparam int HOLD_START      = 2500;
  localparam int HOLD_LEN        = 300;
  localparam int STEADY_RX_START = 8000;
  localparam int STEADY_RX_END   = 12000;
  localparam int STEADY_TX_FIRST = 400;
  localparam int STEADY_TX_LAST  = 550;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int TAIL_CYCLES     = 2 * CAPACITY + 40;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata  = '0;
  logic [1:0]   s_tuser  = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic [2:0]   m_tuser;

  int fail_count;
  int results_due;
  int items_sent   = 0;
  int rx_cycle     = 0;
  int quiet_cycles = 0;

  logic [63:0] key_pool [POOL_SIZE];
  int          pool_order [POOL_SIZE];

  always #5 clk = ~clk;

  sorted_key_depth_table #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  skdt_table_checker #(.CAPACITY(CAPACITY)) table_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // Receiver: random stalls, one long hold-off and one stretch without stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_cycle <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
        m_tready <= 1'b0;
      end else if (rx_cycle >= STEADY_RX_START && rx_cycle < STEADY_RX_END) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] fresh_key();
    return {$urandom, $urandom};
  endfunction

  // Mostly random values, now and then the signed extremes
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_depth();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic skdt_pkg::kind_t pick_lookup();
    return $urandom_range(0, 1) ? skdt_pkg::KIND_LOOKUP_VALUE : skdt_pkg::KIND_LOOKUP_DEPTH;
  endfunction

  // Offer one request item and hold it until accepted
  task automatic send_item(input skdt_pkg::kind_t kind, input logic [63:0] k,
                           input logic [31:0] v, input logic [7:0] d);
    if (!(items_sent >= STEADY_TX_FIRST && items_sent < STEADY_TX_LAST) &&
        $urandom_range(0, 99) < 7) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {d, v, k};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Drop valid and wait until every result item has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  // Clear, fill past capacity, then hit the full table with updates and lookups
  task automatic fill_episode();
    int j;
    int pick;
    int tmp;
    for (j = 0; j < POOL_SIZE; j++) pool_order[j] = j;
    for (j = POOL_SIZE - 1; j > 0; j--) begin
      pick = $urandom_range(0, j);
      tmp = pool_order[j];
      pool_order[j] = pool_order[pick];
      pool_order[pick] = tmp;
    end
    send_item(skdt_pkg::KIND_CLEAR, fresh_key(), pick_value(), pick_depth());
    for (j = 0; j < CAPACITY + 6; j++)
      send_item(skdt_pkg::KIND_INSERT, key_pool[pool_order[j]], pick_value(), pick_depth());
    send_item(skdt_pkg::KIND_INSERT, fresh_key(), pick_value(), pick_depth());
    repeat (12) begin
      pick = pool_order[$urandom_range(0, CAPACITY - 1)];
      case ($urandom_range(0, 3))
        0: send_item(skdt_pkg::KIND_INSERT, key_pool[pick], pick_value(), pick_depth());
        1: send_item(skdt_pkg::KIND_LOOKUP_VALUE, key_pool[pick], pick_value(),
                     pick_depth());
        2: send_item(skdt_pkg::KIND_LOOKUP_DEPTH, key_pool[pick], pick_value(),
                     pick_depth());
        default: begin
          pick = pool_order[$urandom_range(CAPACITY, CAPACITY + 5)];
          send_item(pick_lookup(), key_pool[pick], pick_value(), pick_depth());
        end
      endcase
    end
    drain();
  endtask

  // Mixed traffic on pool keys with some fresh keys as noise
  task automatic mixed_episode();
    int              n;
    int              r;
    skdt_pkg::kind_t kind;
    logic [63:0]     k;
    n = $urandom_range(10, 40);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 45) kind = skdt_pkg::KIND_INSERT;
      else if (r < 70) kind = skdt_pkg::KIND_LOOKUP_VALUE;
      else if (r < 97) kind = skdt_pkg::KIND_LOOKUP_DEPTH;
      else kind = skdt_pkg::KIND_CLEAR;
      if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else k = fresh_key();
      send_item(kind, k, pick_value(), pick_depth());
    end
  endtask

  initial begin
    int   i;
    int   j;
    int   episode;
    logic clash;

    // Build a pool of distinct keys: extremes, random keys and close neighbours
    for (i = 0; i < POOL_SIZE; i++) begin
      case (i)
        0: key_pool[i] = '0;
        1: key_pool[i] = '1;
        2: key_pool[i] = 64'h8000_0000_0000_0000;
        3: key_pool[i] = 64'h7fff_ffff_ffff_ffff;
        default: begin
          do begin
            if (i % 3 == 0)
              key_pool[i] = key_pool[i-1] ^ {56'd0, 8'($urandom_range(1, 255))};
            else
              key_pool[i] = fresh_key();
            clash = 1'b0;
            for (j = 0; j < i; j++)
              if (key_pool[j] == key_pool[i]) clash = 1'b1;
          end while (clash);
        end
      endcase
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty misses, extremes, update, clear
    send_item(skdt_pkg::KIND_LOOKUP_VALUE, key_pool[0], pick_value(), 8'hff);
    send_item(skdt_pkg::KIND_LOOKUP_DEPTH, key_pool[1], pick_value(), 8'h00);
    send_item(skdt_pkg::KIND_INSERT, key_pool[0], 32'h8000_0000, 8'h00);
    send_item(skdt_pkg::KIND_INSERT, key_pool[1], 32'h7fff_ffff, 8'hff);
    send_item(skdt_pkg::KIND_INSERT, key_pool[2], 32'hffff_ffff, 8'h5a);
    send_item(skdt_pkg::KIND_INSERT, key_pool[3], 32'h0000_0000, 8'ha5);
    send_item(skdt_pkg::KIND_LOOKUP_VALUE, key_pool[0], pick_value(), 8'h11);
    send_item(skdt_pkg::KIND_LOOKUP_VALUE, key_pool[1], pick_value(), 8'h22);
    send_item(skdt_pkg::KIND_LOOKUP_DEPTH, key_pool[1], pick_value(), 8'h33);
    send_item(skdt_pkg::KIND_LOOKUP_DEPTH, key_pool[0], pick_value(), 8'h44);
    send_item(skdt_pkg::KIND_INSERT, key_pool[0], 32'd123, 8'd200);
    send_item(skdt_pkg::KIND_LOOKUP_VALUE, key_pool[0], pick_value(), 8'h00);
    send_item(skdt_pkg::KIND_LOOKUP_DEPTH, key_pool[0], pick_value(), 8'h00);
    send_item(skdt_pkg::KIND_LOOKUP_VALUE, key_pool[3] - 64'd1, pick_value(), 8'h00);
    send_item(skdt_pkg::KIND_LOOKUP_DEPTH, 64'd1, pick_value(), 8'h00);
    send_item(skdt_pkg::KIND_CLEAR, '1, 32'hffff_ffff, 8'hff);
    send_item(skdt_pkg::KIND_LOOKUP_VALUE, key_pool[1], pick_value(), 8'h00);
    send_item(skdt_pkg::KIND_CLEAR, '0, 32'h0, 8'h00);
    send_item(skdt_pkg::KIND_INSERT, key_pool[2], pick_value(), 8'h81);
    send_item(skdt_pkg::KIND_LOOKUP_VALUE, key_pool[2], pick_value(), 8'h00);
    drain();

    // Random episodes, the first one always a fill to capacity
    episode = 0;
    while (items_sent < ITEM_TARGET) begin
      if (episode == 0 || $urandom_range(0, 5) == 0) fill_episode();
      else mixed_episode();
      episode++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
